// File: src/kmsd_pkg.sv
// shared constants, types and helper functions for the key matrix scanner
`timescale 1ns / 1ps

package kmsd_pkg;

    localparam int ROWS       = 4;
    localparam int COLS       = 4;
    localparam int COL_BITS   = 4;
    localparam int MASK_BITS  = 16;
    localparam int DRIVE_BITS = 4;
    localparam int COUNT_W    = 4;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COLS_USED  = (COLS < COL_BITS) ? COLS : COL_BITS;

    localparam int S_TDATA_W  = ((COL_BITS + 7) / 8) * 8;
    localparam int M_FIELD_W  = DRIVE_BITS + MASK_BITS;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] MATCH_SCANS_RESET = COUNT_W'(2);

    typedef logic [ROW_W-1:0]      row_idx_t;
    typedef logic [MASK_BITS-1:0]  key_mask_t;
    typedef logic [COL_BITS-1:0]   col_levels_t;
    typedef logic [DRIVE_BITS-1:0] row_drive_t;
    typedef logic [COUNT_W-1:0]    count_t;

    typedef struct packed {
        key_mask_t  raw_mask;
        logic       done;
        row_drive_t row_drive;
    } scan_res_t;

    // pressed keys of the driven row placed at bit row*COLS+col
    function automatic key_mask_t row_bits(row_idx_t row, col_levels_t levels);
        key_mask_t bits;
        bits = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS_USED; c++)
            begin
                if ((r * COLS + c) < MASK_BITS)
                begin
                    if ((row == ROW_W'(r)) && !levels[c])
                        bits[r * COLS + c] = 1'b1;
                end
            end
        end
        return bits;
    endfunction

    // active-low drive, all ones when the row has no drive bit
    function automatic row_drive_t drive_for(row_idx_t row);
        row_drive_t d;
        d = '1;
        for (int r = 0; r < DRIVE_BITS; r++)
        begin
            if ((r < ROWS) && (row == ROW_W'(r)))
                d[r] = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: src/key_matrix_scan_debounce.sv
// top level: input register, scan and debounce logic, result register
// throughput: one request per cycle while m_axis_tready holds, set by the single-pass scan and compare logic
// a waiting result holds one more request in the input register, then tready drops
// reset: asynchronous active low, first row, all scan and debounce masks and the match count clear
// reset: sample count register returns to 2
`timescale 1ns / 1ps

module key_matrix_scan_debounce
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kmsd_pkg::COUNT_W-1:0]   cfg_data,      // required matching scans
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [kmsd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // col_levels, zero pad
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [kmsd_pkg::M_TDATA_W-1:0] m_axis_tdata,  // row_drive, stable_keys, zero pad
    output logic                           m_axis_tlast   // scan_complete
);

    kmsd_pkg::count_t      samples_reg;
    logic                  in_valid_reg;
    kmsd_pkg::col_levels_t in_levels_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    kmsd_pkg::row_drive_t  out_drive_reg;
    kmsd_pkg::key_mask_t   out_stable_reg;
    logic                  out_last_reg;
    logic                  advance;
    kmsd_pkg::scan_res_t   scan_res;
    kmsd_pkg::key_mask_t   stable_cur;
    kmsd_pkg::key_mask_t   stable_out;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            samples_reg <= kmsd_pkg::MATCH_SCANS_RESET;
        else if (cfg_valid && cfg_ready)
            samples_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_levels_reg <= s_axis_tdata[kmsd_pkg::COL_BITS-1:0];
    end

    kmsd_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .col_levels (in_levels_reg),
        .scan_res   (scan_res)
    );

    kmsd_debounce u_debounce
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .scan_res   (scan_res),
        .samples    (samples_reg),
        .stable_cur (stable_cur),
        .stable_out (stable_out)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_drive_reg  <= scan_res.row_drive;
            out_stable_reg <= stable_out;
            out_last_reg   <= scan_res.done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = kmsd_pkg::M_TDATA_W'({out_stable_reg, out_drive_reg});

    // a completed scan always hands back the first row's drive
    a_last_drives_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (out_drive_reg == kmsd_pkg::drive_for('0)))
        else $error("scan_complete without first row drive");

    // the held result always matches the debounced mask
    a_result_tracks_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_stable_reg == stable_cur))
        else $error("result stable mask out of step with debounce state");

    // stable mask moves only on a request that ends a scan
    a_stable_only_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !scan_res.done) |=> $stable(stable_cur))
        else $error("stable mask changed mid-scan");

    // the input stage is open whenever it is empty
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("empty input stage not ready");

endmodule

// File: src/kmsd_scan.sv
// row sequencer and raw mask accumulation
`timescale 1ns / 1ps

module kmsd_scan
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step_en,
    input  kmsd_pkg::col_levels_t   col_levels,
    output kmsd_pkg::scan_res_t     scan_res
);

    kmsd_pkg::row_idx_t  row_reg;
    kmsd_pkg::row_idx_t  row_next;
    kmsd_pkg::key_mask_t partial_reg;
    kmsd_pkg::key_mask_t partial_next;
    kmsd_pkg::key_mask_t mask_now;
    logic                last_row;

    always_comb
    begin
        mask_now = partial_reg | kmsd_pkg::row_bits(row_reg, col_levels);
        last_row = (row_reg == kmsd_pkg::ROW_W'(kmsd_pkg::ROWS - 1));
        if (last_row)
        begin
            row_next     = '0;
            partial_next = '0;
        end
        else
        begin
            row_next     = row_reg + kmsd_pkg::ROW_W'(1);
            partial_next = mask_now;
        end
        scan_res.raw_mask  = mask_now;
        scan_res.done      = last_row;
        scan_res.row_drive = kmsd_pkg::drive_for(row_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            partial_reg <= '0;
        end
        else if (step_en)
        begin
            row_reg     <= row_next;
            partial_reg <= partial_next;
        end
    end

endmodule

// File: src/kmsd_debounce.sv
// scan-to-scan match counter and stable mask
`timescale 1ns / 1ps

module kmsd_debounce
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  kmsd_pkg::scan_res_t   scan_res,
    input  kmsd_pkg::count_t      samples,
    output kmsd_pkg::key_mask_t   stable_cur,
    output kmsd_pkg::key_mask_t   stable_out
);

    kmsd_pkg::key_mask_t prev_reg;
    kmsd_pkg::key_mask_t prev_next;
    kmsd_pkg::count_t    count_reg;
    kmsd_pkg::count_t    count_next;
    kmsd_pkg::key_mask_t stable_reg;
    kmsd_pkg::key_mask_t stable_next;

    always_comb
    begin
        prev_next   = prev_reg;
        count_next  = count_reg;
        stable_next = stable_reg;
        if (scan_res.done)
        begin
            if (scan_res.raw_mask == prev_reg)
            begin
                if (count_reg < samples)
                    count_next = count_reg + kmsd_pkg::COUNT_W'(1);
                if (count_next >= samples)
                    stable_next = scan_res.raw_mask;
            end
            else
            begin
                prev_next  = scan_res.raw_mask;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            count_reg  <= '0;
            stable_reg <= '0;
        end
        else if (step_en)
        begin
            prev_reg   <= prev_next;
            count_reg  <= count_next;
            stable_reg <= stable_next;
        end
    end

    assign stable_cur = stable_reg;
    assign stable_out = stable_next;

endmodule

// File: tb/sv/key_matrix_scan_debounce_tb.sv
// self-checking testbench for the key matrix scanner with debounce
`timescale 1ns / 1ps

module key_matrix_scan_debounce_tb;

    typedef struct {
        kmsd_pkg::row_drive_t drive;
        kmsd_pkg::key_mask_t  keys;
        logic                 done;
    } scan_out_t;

    typedef struct {
        kmsd_pkg::col_levels_t levels;
        bit                    typed;
        kmsd_pkg::row_drive_t  drive;
        kmsd_pkg::key_mask_t   keys;
        logic                  done;
    } dir_row_t;

    localparam int NUM_DIRECTED = 20;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 150;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [kmsd_pkg::COUNT_W-1:0]   cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [kmsd_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [kmsd_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    // scanner image
    kmsd_pkg::count_t    debounce_cfg;
    kmsd_pkg::row_idx_t  row_pos;
    kmsd_pkg::key_mask_t partial_keys;
    kmsd_pkg::key_mask_t last_raw;
    kmsd_pkg::count_t    match_cnt;
    kmsd_pkg::key_mask_t stable_img;

    scan_out_t pending_scans[$];
    dir_row_t  directed_rows [0:NUM_DIRECTED-1];
    bit        quiet;
    int        mismatch_count;
    int        results_checked;
    int        samples_sent;
    int        phase_items;
    int        settings_used;

    key_matrix_scan_debounce uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("key_matrix_scan_debounce test failed");
        $finish;
    end

    function automatic void image_reset();
        debounce_cfg = kmsd_pkg::MATCH_SCANS_RESET;
        row_pos      = '0;
        partial_keys = '0;
        last_raw     = '0;
        match_cnt    = '0;
        stable_img   = '0;
    endfunction

    function automatic void close_scan(kmsd_pkg::key_mask_t raw);
        if (raw == last_raw)
        begin
            if (match_cnt < debounce_cfg)
                match_cnt = match_cnt + 1'b1;
            if (match_cnt >= debounce_cfg)
                stable_img = raw;
        end
        else
        begin
            last_raw  = raw;
            match_cnt = '0;
        end
    endfunction

    function automatic scan_out_t scan_sample(kmsd_pkg::col_levels_t levels);
        scan_out_t res;
        int        bit_pos;
        res.done = 1'b0;
        for (int c = 0; c < kmsd_pkg::COLS_USED; c++)
        begin
            bit_pos = int'(row_pos) * kmsd_pkg::COLS + c;
            if (!levels[c] && bit_pos < kmsd_pkg::MASK_BITS)
                partial_keys[bit_pos] = 1'b1;
        end
        if (int'(row_pos) + 1 >= kmsd_pkg::ROWS)
        begin
            close_scan(partial_keys);
            partial_keys = '0;
            row_pos      = '0;
            res.done     = 1'b1;
        end
        else
        begin
            row_pos = row_pos + 1'b1;
        end
        res.drive = '1;
        if (int'(row_pos) < kmsd_pkg::DRIVE_BITS)
            res.drive[row_pos] = 1'b0;
        res.keys = stable_img;
        return res;
    endfunction

    task automatic send_sample(kmsd_pkg::col_levels_t levels, bit typed, scan_out_t typed_exp);
        scan_out_t exp_res;
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < 17)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= kmsd_pkg::S_TDATA_W'(levels);
        do
            @(posedge clk);
        while (!s_axis_tready);
        exp_res = scan_sample(levels);
        pending_scans.push_back(typed ? typed_exp : exp_res);
        samples_sent++;
        phase_items++;
    endtask

    task automatic send_levels(kmsd_pkg::col_levels_t levels);
        scan_out_t none;
        none = '{default: '0};
        send_sample(levels, 1'b0, none);
    endtask

    // one row's worth of a key mask, from the row the scanner drives next
    function automatic kmsd_pkg::col_levels_t row_levels(kmsd_pkg::key_mask_t mask, int row);
        return ~mask[row * kmsd_pkg::COLS +: kmsd_pkg::COL_BITS];
    endfunction

    task automatic send_scan(kmsd_pkg::key_mask_t mask, int rows);
        int row;
        for (int k = 0; k < rows; k++)
        begin
            row = int'(row_pos);
            send_levels(row_levels(mask, row));
        end
    endtask

    task automatic write_debounce(kmsd_pkg::count_t value);
        s_axis_tvalid <= 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        debounce_cfg = value;
        settings_used++;
    endtask

    task automatic check_result();
        scan_out_t            exp_res;
        kmsd_pkg::row_drive_t got_drive;
        kmsd_pkg::key_mask_t  got_keys;
        got_drive = m_axis_tdata[kmsd_pkg::DRIVE_BITS-1:0];
        got_keys  = m_axis_tdata[kmsd_pkg::DRIVE_BITS +: kmsd_pkg::MASK_BITS];
        if (pending_scans.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("unexpected result: drive %h keys %h last %b",
                         got_drive, got_keys, m_axis_tlast);
            mismatch_count++;
            return;
        end
        exp_res = pending_scans.pop_front();
        results_checked++;
        if (got_drive !== exp_res.drive || got_keys !== exp_res.keys
            || m_axis_tlast !== exp_res.done)
        begin
            if (mismatch_count < 10)
                $display("mismatch at result %0d: ", results_checked,
                         "expected drive %h keys %h last %b, ",
                         exp_res.drive, exp_res.keys, exp_res.done,
                         "got drive %h keys %h last %b",
                         got_drive, got_keys, m_axis_tlast);
            mismatch_count++;
        end
    endtask

    // result side
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 17);
        end
    end

    // random key mask: idle, a few keys, or anything
    function automatic kmsd_pkg::key_mask_t pick_mask();
        kmsd_pkg::key_mask_t mask;
        int                  pick;
        pick = $urandom_range(0, 2);
        mask = '0;
        if (pick == 1)
        begin
            for (int k = 0; k < 3; k++)
                mask[$urandom_range(0, kmsd_pkg::MASK_BITS - 1)] = 1'b1;
        end
        else if (pick == 2)
        begin
            mask = kmsd_pkg::key_mask_t'($urandom);
        end
        return mask;
    endfunction

    initial
    begin
        kmsd_pkg::key_mask_t target;
        kmsd_pkg::key_mask_t bounced;
        int                  repeats;
        int                  action;
        kmsd_pkg::count_t    setting;
        scan_out_t           typed_exp;

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        quiet          = 1'b0;
        mismatch_count = 0;
        results_checked = 0;
        samples_sent   = 0;
        settings_used  = 0;
        image_reset();

        // no keys for one scan, all keys for three, then a mixed pattern
        directed_rows = '{
            '{4'hF, 1'b1, 4'hD, 16'h0000, 1'b0},
            '{4'hF, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'hF, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'hF, 1'b1, 4'hE, 16'h0000, 1'b1},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h0, 1'b1, 4'hE, 16'hFFFF, 1'b1},
            '{4'hE, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h7, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'h5, 1'b0, 4'h0, 16'h0000, 1'b0},
            '{4'hA, 1'b0, 4'h0, 16'h0000, 1'b0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            typed_exp.drive = directed_rows[i].drive;
            typed_exp.keys  = directed_rows[i].keys;
            typed_exp.done  = directed_rows[i].done;
            send_sample(directed_rows[i].levels, directed_rows[i].typed, typed_exp);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       setting = kmsd_pkg::count_t'(1);
                1:       setting = kmsd_pkg::count_t'(15);
                2:       setting = kmsd_pkg::count_t'(0);
                3:       setting = kmsd_pkg::count_t'(2);
                default: setting = kmsd_pkg::count_t'($urandom_range(0, 15));
            endcase
            write_debounce(setting);
            quiet       = (p == 3);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                action = $urandom_range(0, 99);
                if (action < 75)
                begin
                    // held press with the odd bounce
                    target  = pick_mask();
                    repeats = $urandom_range(1, int'(debounce_cfg) + 3);
                    for (int s = 0; s < repeats; s++)
                    begin
                        bounced = target;
                        if ($urandom_range(0, 9) == 0)
                            bounced[$urandom_range(0, kmsd_pkg::MASK_BITS - 1)] ^= 1'b1;
                        send_scan(bounced, kmsd_pkg::ROWS);
                    end
                end
                else if (action < 90)
                begin
                    repeats = $urandom_range(1, 6);
                    for (int s = 0; s < repeats; s++)
                        send_levels(kmsd_pkg::col_levels_t'($urandom));
                end
                else
                begin
                    send_scan(pick_mask(), $urandom_range(1, kmsd_pkg::ROWS - 1));
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d column samples over %0d debounce settings", samples_sent,
                 settings_used + 1);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("key_matrix_scan_debounce test passed");
        else
            $display("key_matrix_scan_debounce test failed");
        $finish;
    end

endmodule

// File: filelist.f
src/kmsd_pkg.sv
src/kmsd_scan.sv
src/kmsd_debounce.sv
src/key_matrix_scan_debounce.sv
tb/sv/key_matrix_scan_debounce_tb.sv
